FILE: rtl/core/exl_pkg.sv
// exl_pkg: shared types, token kind codes, character codes and the fraction
// weight table of the expression lexer
// no dependencies; imported by every module of the lexer
`timescale 1ns / 1ps
`default_nettype none

package exl_pkg;

    // default parameter values
    localparam int FRAC_DIGITS_DEF   = 5;
    localparam int POSITION_BITS_DEF = 16;

    // token kinds
    localparam logic [4:0] K_NUM     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_PLUS    = 5'd2;
    localparam logic [4:0] K_MINUS   = 5'd3;
    localparam logic [4:0] K_SLASH   = 5'd4;
    localparam logic [4:0] K_STAR    = 5'd5;
    localparam logic [4:0] K_CARET   = 5'd6;
    localparam logic [4:0] K_PERCENT = 5'd7;
    localparam logic [4:0] K_LPAREN  = 5'd8;
    localparam logic [4:0] K_RPAREN  = 5'd9;
    localparam logic [4:0] K_LBRACK  = 5'd10;
    localparam logic [4:0] K_RBRACK  = 5'd11;
    localparam logic [4:0] K_COMMA   = 5'd12;
    localparam logic [4:0] K_EQUAL   = 5'd13;
    localparam logic [4:0] K_LESS    = 5'd14;
    localparam logic [4:0] K_LESS_EQ = 5'd15;
    localparam logic [4:0] K_GREATER = 5'd16;
    localparam logic [4:0] K_GREAT_EQ = 5'd17;
    localparam logic [4:0] K_NEWLINE = 5'd18;
    localparam logic [4:0] K_END     = 5'd19;
    localparam logic [4:0] K_ERROR   = 5'd20;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    // output queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one result token
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] tok_line;
        logic [15:0] tok_column;
        logic [15:0] tok_length;
        logic [31:0] num_int;
        logic [15:0] num_frac;
        logic        num_ovf;
        logic        last;
    } t_token;

    // tokens produced by one character, written to the queue together
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    // floor(2^16 / 10^(k+1)) for fraction digit k
    function automatic logic [15:0] frac_weight(input logic [3:0] k);
        logic [15:0] w;
        case (k)
            4'd0:    w = 16'd6553;
            4'd1:    w = 16'd655;
            4'd2:    w = 16'd65;
            4'd3:    w = 16'd6;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

    // single-character operator kinds, error for anything unlisted
    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_PLUS:    k = K_PLUS;
            CH_MINUS:   k = K_MINUS;
            CH_SLASH:   k = K_SLASH;
            CH_STAR:    k = K_STAR;
            CH_CARET:   k = K_CARET;
            CH_PERCENT: k = K_PERCENT;
            CH_LPAREN:  k = K_LPAREN;
            CH_RPAREN:  k = K_RPAREN;
            CH_LBRACK:  k = K_LBRACK;
            CH_RBRACK:  k = K_RBRACK;
            CH_COMMA:   k = K_COMMA;
            CH_EQ:      k = K_EQUAL;
            default:    k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/exl_scan.sv
// exl_scan: scanner state and the per-character token logic
// depends on exl_pkg; produces up to two tokens per accepted character
`timescale 1ns / 1ps
`default_nettype none

module exl_scan #(
    parameter int FRAC_DIGITS   = exl_pkg::FRAC_DIGITS_DEF,
    parameter int POSITION_BITS = exl_pkg::POSITION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_char,
    output exl_pkg::t_push     o_push
);
    import exl_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_INT     = 3'd1;
    localparam logic [2:0] M_FRAC    = 3'd2;
    localparam logic [2:0] M_IDENT   = 3'd3;
    localparam logic [2:0] M_LESS    = 3'd4;
    localparam logic [2:0] M_GREATER = 3'd5;
    localparam logic [2:0] M_DOT     = 3'd6;
    localparam logic [2:0] M_COMMENT = 3'd7;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [3:0] FRAC_LIMIT = 4'(FRAC_DIGITS);

    logic [2:0]               r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col,  n_col;
    logic [15:0]              r_len,  n_len;
    logic [31:0]              r_int,  n_int;
    logic [15:0]              r_frac, n_frac;
    logic [3:0]               r_cnt,  n_cnt;
    logic                     r_ovf,  n_ovf;

    logic                     is_dig, is_id;
    logic [3:0]               digit;
    logic [POSITION_BITS-1:0] col_inc;
    logic [15:0]              len_inc;
    logic [15:0]              line16, col16, pend_col;
    logic [31:0]              col32;
    logic [35:0]              int_sum;
    logic [31:0]              int_next;
    logic                     int_sat;
    logic [19:0]              frac_prod;
    logic [15:0]              frac_next;
    logic                     frac_keep;
    t_token                   flush_tok;
    t_push                    push;

    // character classes
    assign is_dig = (i_char inside {[CH_0:CH_9]});
    assign is_id  = (i_char inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER});
    assign digit  = 4'(i_char - CH_0);

    // saturating position and length steps
    assign col_inc = (r_col != POS_MAX) ? r_col + POS_ONE : r_col;
    assign len_inc = (r_len != 16'hFFFF) ? r_len + 16'd1 : r_len;

    // positions as shown on the output
    assign col32    = 32'(r_col);
    assign line16   = 16'(32'(r_line));
    assign col16    = col32[15:0];
    assign pend_col = (col32 > 32'(r_len)) ? 16'(col32 - 32'(r_len)) : 16'd1;

    // integer digit: acc * 10 + d, saturating
    assign int_sum  = ({4'd0, r_int} << 3) + ({4'd0, r_int} << 1) + 36'(digit);
    assign int_sat  = (int_sum[35:32] != 4'd0);
    assign int_next = int_sat ? 32'hFFFF_FFFF : int_sum[31:0];

    // fraction digit weighted by the table
    assign frac_keep = (r_cnt < FRAC_LIMIT);
    assign frac_prod = 20'(digit) * 20'(frac_weight(r_cnt));
    assign frac_next = r_frac + frac_prod[15:0];

    // token for whatever is pending
    always_comb begin
        flush_tok            = '0;
        flush_tok.tok_line   = line16;
        flush_tok.tok_column = pend_col;
        flush_tok.tok_length = r_len;
        case (r_mode)
            M_INT, M_FRAC: begin
                flush_tok.kind     = K_NUM;
                flush_tok.num_int  = r_int;
                flush_tok.num_frac = r_frac;
                flush_tok.num_ovf  = r_ovf;
            end
            M_IDENT:   flush_tok.kind = K_IDENT;
            M_LESS:    flush_tok.kind = K_LESS;
            M_GREATER: flush_tok.kind = K_GREATER;
            default:   flush_tok.kind = K_ERROR;
        endcase
    end

    // next state and tokens for the current character
    always_comb begin
        logic   go_idle;
        logic   flushed;
        logic   it_emit;
        t_token it;

        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_len   = r_len;
        n_int   = r_int;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        push    = '0;
        go_idle = 1'b0;
        flushed = 1'b0;
        it_emit = 1'b0;
        it      = '0;

        // continue or end the pending token
        case (r_mode)
            M_INT: begin
                if (is_dig) begin
                    n_int = int_next;
                    n_ovf = r_ovf | int_sat;
                    n_len = len_inc;
                    n_col = col_inc;
                end else if (i_char == CH_DOT) begin
                    n_mode = M_FRAC;
                    n_len  = len_inc;
                    n_col  = col_inc;
                end else begin
                    flushed = 1'b1;
                end
            end
            M_FRAC, M_DOT: begin
                if (is_dig) begin
                    n_mode = M_FRAC;
                    if (frac_keep) begin
                        n_frac = frac_next;
                        n_cnt  = r_cnt + 4'd1;
                    end
                    n_len = len_inc;
                    n_col = col_inc;
                end else begin
                    flushed = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_id || is_dig) begin
                    n_len = len_inc;
                    n_col = col_inc;
                end else begin
                    flushed = 1'b1;
                end
            end
            M_LESS, M_GREATER: begin
                if (i_char == CH_EQ) begin
                    push.cnt             = 2'd1;
                    push.tok0.kind       = (r_mode == M_LESS) ? K_LESS_EQ : K_GREAT_EQ;
                    push.tok0.tok_line   = line16;
                    push.tok0.tok_column = pend_col;
                    push.tok0.tok_length = len_inc;
                    push.tok0.last       = 1'b1;
                    n_col  = col_inc;
                    n_mode = M_IDLE;
                    n_len  = '0;
                end else begin
                    flushed = 1'b1;
                end
            end
            M_COMMENT: begin
                if (i_char != CH_LF && i_char != CH_NUL) begin
                    n_col = col_inc;
                end else begin
                    go_idle = 1'b1;
                end
            end
            default: go_idle = 1'b1;
        endcase

        // character handled from idle, pending fields start cleared
        if (go_idle || flushed) begin
            n_mode = M_IDLE;
            n_len  = '0;
            n_int  = '0;
            n_frac = '0;
            n_cnt  = '0;
            n_ovf  = 1'b0;
            it.tok_line   = line16;
            it.tok_column = col16;
            it.tok_length = 16'd1;
            case (i_char) inside
                CH_SPACE, CH_TAB, CH_CR: n_col = col_inc;
                CH_HASH: begin
                    n_mode = M_COMMENT;
                    n_col  = col_inc;
                end
                [CH_0:CH_9]: begin
                    n_mode = M_INT;
                    n_len  = 16'd1;
                    n_int  = 32'(digit);
                    n_col  = col_inc;
                end
                [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER: begin
                    n_mode = M_IDENT;
                    n_len  = 16'd1;
                    n_col  = col_inc;
                end
                CH_DOT: begin
                    n_mode = M_DOT;
                    n_len  = 16'd1;
                    n_col  = col_inc;
                end
                CH_LT: begin
                    n_mode = M_LESS;
                    n_len  = 16'd1;
                    n_col  = col_inc;
                end
                CH_GT: begin
                    n_mode = M_GREATER;
                    n_len  = 16'd1;
                    n_col  = col_inc;
                end
                CH_LF: begin
                    it_emit = 1'b1;
                    it.kind = K_NEWLINE;
                    n_line  = (r_line != POS_MAX) ? r_line + POS_ONE : r_line;
                    n_col   = POS_ONE;
                end
                CH_NUL: begin
                    it_emit       = 1'b1;
                    it.kind       = K_END;
                    it.tok_length = 16'd0;
                    n_line        = POS_ONE;
                    n_col         = POS_ONE;
                end
                default: begin
                    it_emit = 1'b1;
                    it.kind = op_kind(i_char);
                    n_col   = col_inc;
                end
            endcase

            // order the pending token ahead of the new one
            it.last = 1'b1;
            if (flushed) begin
                push.tok0      = flush_tok;
                push.tok0.last = !it_emit;
                push.tok1      = it;
                push.cnt       = it_emit ? 2'd2 : 2'd1;
            end else begin
                push.tok0 = it;
                push.cnt  = it_emit ? 2'd1 : 2'd0;
            end
        end
    end

    // state update on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= POS_ONE;
            r_col  <= POS_ONE;
            r_len  <= '0;
            r_int  <= '0;
            r_frac <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_len  <= n_len;
            r_int  <= n_int;
            r_frac <= n_frac;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
        end
    end

    always_comb begin
        o_push     = push;
        o_push.cnt = i_step ? push.cnt : 2'd0;
    end

endmodule

`default_nettype wire

FILE: rtl/core/exl_tok_fifo.sv
// exl_tok_fifo: small result queue taking up to two tokens and giving one per cycle
// depends on exl_pkg for the token type and queue geometry
`timescale 1ns / 1ps
`default_nettype none

module exl_tok_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire exl_pkg::t_push i_push,
    input  wire logic          i_pop,
    output exl_pkg::t_token    o_tok,
    output logic               o_valid,
    output logic               o_room
);
    import exl_pkg::*;

    t_token               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;
    logic                 pop;
    logic [Q_PTR_W-1:0]   wr_ptr1;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign pop     = i_pop && o_valid;
    assign wr_ptr1 = r_wr_ptr + Q_PTR_W'(1);
    assign o_tok   = r_mem[r_rd_ptr];

    // pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_push.cnt);
        n_rd_ptr = pop ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + Q_CNT_W'(i_push.cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.tok1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/expression_lexer_top.sv
// expression_lexer_top: streaming lexer, one source character in, tokens out
// depends on exl_pkg, exl_scan and exl_tok_fifo
//
//   channel  | direction | tdata                         | tuser       | tlast
//   s_axis   | in        | [7:0] character               | -           | -
//   m_axis   | out       | line, column, length, integer,| [4:0] kind  | last token
//            |           | fraction, overflow            |             | of a character
//
// one character is taken per cycle unless the input stalls; it is scanned while it
// sits in the input register, and its tokens are written to the result queue, whose registers drive the output
// a character yields at most two tokens; the four-entry result queue drains one
// token per cycle while the output is ready, so the input keeps full rate while each
// character leaves one token or none, and slows to the output rate when characters
// close two tokens; the input stalls while the queue has under two free entries
// synchronous active-low reset returns line and column to 1 and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module expression_lexer_top #(
    parameter int FRAC_DIGITS   = exl_pkg::FRAC_DIGITS_DEF,
    parameter int POSITION_BITS = exl_pkg::POSITION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] character
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [103:0]       m_axis_tdata,   // [15:0] line, [31:16] column,
                                               // [47:32] length, [79:48] integer,
                                               // [95:80] fraction, [96] overflow,
                                               // [103:97] zero
    output logic [4:0]         m_axis_tuser,   // [4:0] token kind
    output logic               m_axis_tlast    // last token of a character
);
    import exl_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        step;
    logic        room;
    t_push       push;
    t_token      tok;

    // input register
    assign step          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
        end
    end

    // scanner
    exl_scan #(
        .FRAC_DIGITS   (FRAC_DIGITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_in_char),
        .o_push  (push)
    );

    // result queue
    exl_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_tok   (tok),
        .o_valid (m_axis_tvalid),
        .o_room  (room)
    );

    // output packing
    assign m_axis_tdata = {7'd0, tok.num_ovf, tok.num_frac, tok.num_int,
                           tok.tok_length, tok.tok_column, tok.tok_line};
    assign m_axis_tuser = tok.kind;
    assign m_axis_tlast = tok.last;

endmodule

`default_nettype wire

FILE: rtl/core/exl_checker.sv
// exl_checker: port-level assertions for the expression lexer, bound to the top
// depends on exl_pkg for token kind codes
`timescale 1ns / 1ps
`default_nettype none

module exl_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [103:0]  m_axis_tdata,
    input wire logic [4:0]    m_axis_tuser,
    input wire logic          m_axis_tlast
);
    import exl_pkg::*;

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result keeps its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // newline and end tokens always close their character, end has no length
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_NEWLINE || m_axis_tuser == K_END) |->
            m_axis_tlast && ((m_axis_tuser == K_END) == (m_axis_tdata[47:32] == 16'd0)))
        else $error("newline or end token malformed");

    // only number tokens carry a value
    a_value_only_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_NUM |-> m_axis_tdata[96:48] == '0)
        else $error("value on a non-number token");

    // known kind, zero padding, columns count from one
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= K_ERROR && m_axis_tdata[103:97] == '0
            && m_axis_tdata[31:16] != 16'd0)
        else $error("token kind, padding or column out of range");

endmodule

bind expression_lexer_top exl_checker u_exl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
